>>> rtl/core/dfs_pkg.sv
`default_nettype none

package dfs_pkg;

   localparam int MAX_NODES  = 16;
   localparam int NODE_SLOTS = 16;
   localparam int LIVE_NODES = (MAX_NODES < NODE_SLOTS) ? MAX_NODES : NODE_SLOTS;
   localparam int NODE_W     = $clog2(NODE_SLOTS);
   localparam int DEPTH_W    = $clog2(NODE_SLOTS + 1);
   localparam int OP_W       = 2;

   typedef logic [NODE_W-1:0]             node_type;
   typedef logic [NODE_SLOTS-1:0]         row_type;
   typedef row_type [NODE_SLOTS-1:0]      adj_type;
   typedef logic [DEPTH_W-1:0]            depth_type;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_FIND  = 2'd2
   } op_type;

   localparam int GRID_EDGE_COUNT = 12;
   localparam int GRID_EDGES [GRID_EDGE_COUNT][2] = '{
      '{0, 1}, '{0, 3}, '{1, 2}, '{1, 4}, '{2, 5}, '{3, 4},
      '{3, 6}, '{4, 5}, '{4, 7}, '{5, 8}, '{6, 7}, '{7, 8}
   };

   typedef struct packed {
      logic clear;
      logic add;
      logic start;
      logic push;
      logic pop;
      logic pop_load;
      logic load_path;
      logic load_miss;
      logic next_beat;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic depth_zero;
      logic depth_one;
      logic cand_any;
      logic out_last;
   } status_type;

   function automatic adj_type grid_adjacency();
      adj_type adj;
      int      u;
      int      v;
      adj = '0;
      for (int i = 0; i < GRID_EDGE_COUNT; i++) begin
         u = GRID_EDGES[i][0];
         v = GRID_EDGES[i][1];
         if (u < LIVE_NODES && v < LIVE_NODES) begin
            adj[u][v] = 1'b1;
            adj[v][u] = 1'b1;
         end
      end
      return adj;
   endfunction

   function automatic row_type live_mask();
      row_type m;
      for (int i = 0; i < NODE_SLOTS; i++) begin
         m[i] = (i < LIVE_NODES);
      end
      return m;
   endfunction

   function automatic node_type lowest_set(row_type r);
      node_type n;
      n = '0;
      for (int i = NODE_SLOTS - 1; i >= 0; i--) begin
         if (r[i]) begin
            n = node_type'(i);
         end
      end
      return n;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/dfs_req_if.sv
`default_nettype none

interface dfs_req_if;
   logic                  valid;
   logic                  ready;
   logic [dfs_pkg::OP_W-1:0] op;
   dfs_pkg::node_type     node_a;
   dfs_pkg::node_type     node_b;

   modport source (output valid, output op, output node_a, output node_b, input ready);
   modport sink   (input valid, input op, input node_a, input node_b, output ready);
endinterface

`default_nettype wire

>>> rtl/core/dfs_rsp_if.sv
`default_nettype none

interface dfs_rsp_if;
   logic              valid;
   logic              ready;
   dfs_pkg::node_type path_node;
   logic              found;
   logic              last;

   modport source (output valid, output path_node, output found, output last, input ready);
   modport sink   (input valid, input path_node, input found, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/dfs_datapath.sv
`default_nettype none

module dfs_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dfs_pkg::cmd_type   cmd,
   input  wire dfs_pkg::node_type  node_a,
   input  wire dfs_pkg::node_type  node_b,
   output dfs_pkg::status_type     status,
   output dfs_pkg::node_type       path_node,
   output logic                    found,
   output logic                    last
);

   dfs_pkg::adj_type   adj_ff;
   dfs_pkg::row_type   visited_ff;
   dfs_pkg::depth_type depth_ff;
   dfs_pkg::node_type  top_ff;
   dfs_pkg::node_type  end_ff;
   logic               hit_ff;
   dfs_pkg::node_type  k_ff;
   dfs_pkg::node_type  rd_data_ff;
   dfs_pkg::node_type  path_node_ff;
   logic               found_ff;
   logic               last_ff;

   dfs_pkg::node_type  stack_mem [dfs_pkg::NODE_SLOTS];

   logic               a_live;
   logic               b_live;
   dfs_pkg::row_type   cand;
   dfs_pkg::node_type  next_node;
   dfs_pkg::node_type  rd_addr;
   dfs_pkg::depth_type depth_less2;
   dfs_pkg::depth_type k_plus1;

   assign a_live      = int'(node_a) < dfs_pkg::LIVE_NODES;
   assign b_live      = int'(node_b) < dfs_pkg::LIVE_NODES;
   assign cand        = adj_ff[top_ff] & ~visited_ff & dfs_pkg::live_mask();
   assign next_node   = dfs_pkg::lowest_set(cand);
   assign depth_less2 = depth_ff - dfs_pkg::depth_type'(2);
   assign rd_addr     = cmd.pop ? depth_less2[dfs_pkg::NODE_W-1:0] : k_ff;
   assign k_plus1     = dfs_pkg::depth_type'(k_ff) + dfs_pkg::depth_type'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         adj_ff <= dfs_pkg::grid_adjacency();
      end else if (cmd.clear) begin
         adj_ff <= '0;
      end else if (cmd.add && a_live && b_live) begin
         adj_ff[node_a][node_b] <= 1'b1;
         adj_ff[node_b][node_a] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         visited_ff <= a_live ? (dfs_pkg::row_type'(1) << node_a) : '0;
         depth_ff   <= a_live ? dfs_pkg::depth_type'(1) : '0;
         top_ff     <= node_a;
         end_ff     <= node_b;
         hit_ff     <= a_live && (node_a == node_b);
         k_ff       <= '0;
      end else if (cmd.push) begin
         visited_ff <= visited_ff | (dfs_pkg::row_type'(1) << next_node);
         depth_ff   <= depth_ff + dfs_pkg::depth_type'(1);
         top_ff     <= next_node;
         hit_ff     <= (next_node == end_ff);
      end else if (cmd.pop) begin
         depth_ff   <= depth_ff - dfs_pkg::depth_type'(1);
      end else if (cmd.pop_load) begin
         top_ff     <= rd_data_ff;
      end else if (cmd.next_beat) begin
         k_ff       <= k_ff + dfs_pkg::node_type'(1);
      end

      if (cmd.load_path) begin
         path_node_ff <= rd_data_ff;
         found_ff     <= 1'b1;
         last_ff      <= (k_plus1 == depth_ff);
      end else if (cmd.load_miss) begin
         path_node_ff <= '0;
         found_ff     <= 1'b0;
         last_ff      <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start && a_live) begin
         stack_mem[0] <= node_a;
      end else if (cmd.push) begin
         stack_mem[depth_ff[dfs_pkg::NODE_W-1:0]] <= next_node;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   assign status.hit        = hit_ff;
   assign status.depth_zero = (depth_ff == '0);
   assign status.depth_one  = (depth_ff == dfs_pkg::depth_type'(1));
   assign status.cand_any   = |cand;
   assign status.out_last   = last_ff;

   assign path_node = path_node_ff;
   assign found     = found_ff;
   assign last      = last_ff;

endmodule

`default_nettype wire

>>> rtl/core/dfs_controller.sv
`default_nettype none

module dfs_controller (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic [dfs_pkg::OP_W-1:0] req_op,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire dfs_pkg::status_type     status,
   output dfs_pkg::cmd_type             cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_POP_WAIT,
      S_OUT_READ,
      S_OUT_LOAD,
      S_OUT_WAIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      valid_ff;
   logic      valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      valid_in = valid_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  dfs_pkg::OP_CLEAR: cmd.clear = 1'b1;
                  dfs_pkg::OP_ADD:   cmd.add   = 1'b1;
                  dfs_pkg::OP_FIND: begin
                     cmd.start = 1'b1;
                     state_in  = S_SEARCH;
                  end
                  default: ;
               endcase
            end
         end
         S_SEARCH: begin
            if (status.hit) begin
               state_in = S_OUT_READ;
            end else if (status.depth_zero) begin
               cmd.load_miss = 1'b1;
               valid_in      = 1'b1;
               state_in      = S_OUT_WAIT;
            end else if (status.cand_any) begin
               cmd.push = 1'b1;
            end else begin
               cmd.pop = 1'b1;
               if (!status.depth_one) begin
                  state_in = S_POP_WAIT;
               end
            end
         end
         S_POP_WAIT: begin
            cmd.pop_load = 1'b1;
            state_in     = S_SEARCH;
         end
         S_OUT_READ: begin
            state_in = S_OUT_LOAD;
         end
         S_OUT_LOAD: begin
            cmd.load_path = 1'b1;
            valid_in      = 1'b1;
            state_in      = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (rsp_ready) begin
               valid_in = 1'b0;
               if (status.out_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.next_beat = 1'b1;
                  state_in      = S_OUT_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
            valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

>>> rtl/core/dfs_path_finder.sv
`default_nettype none

// Depth-first path finder over an undirected graph of up to sixteen nodes, held as an
// adjacency bit matrix that comes out of reset as a 3x3 grid (nodes 0..8, row-major).
// A clear or add-edge beat returns nothing. A find beat searches from node_a to node_b,
// trying neighbors in ascending order, and returns the path start first with last set
// on the final beat, or a single beat with found low when no path exists. Each search
// step pushes the lowest unvisited neighbor or pops; a pop that leaves the stack
// non-empty passes through a wait state to reload the top, since the stack sits in
// a single-read-port memory with registered data. Each result beat passes through a
// read state, a load state and a wait state that holds until rsp ready. A new request
// is taken only after the last beat of the current one has been delivered.
module dfs_path_finder (
   input wire logic  clock,
   input wire logic  reset,
   dfs_req_if.sink   req,
   dfs_rsp_if.source rsp
);

   dfs_pkg::cmd_type    cmd;
   dfs_pkg::status_type status;

   dfs_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_op    (req.op),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   dfs_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .node_a    (req.node_a),
      .node_b    (req.node_b),
      .status    (status),
      .path_node (rsp.path_node),
      .found     (rsp.found),
      .last      (rsp.last)
   );

`ifndef ASSERT_OFF
   a_no_accept_while_output: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("request taken while a result beat is pending");

   a_miss_is_single: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.found) |-> (rsp.last && rsp.path_node == '0))
      else $error("not-found beat must be a single last beat with node zero");

   a_path_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && !rsp.last) |=> !req.ready)
      else $error("block went idle before the last path beat");

   a_find_busy: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.op == dfs_pkg::OP_FIND) |=> (!req.ready && !rsp.valid))
      else $error("find request did not start a search");
`endif

endmodule

`default_nettype wire
